// File: design/pt2d_pkg.sv
// ----------------------------------------------------------------------------
// pt2d_pkg
// Types, codes and constants shared by the 2-D point transform.
// ----------------------------------------------------------------------------
package pt2d_pkg;

  localparam int COORD_W    = 16;
  localparam int FUNC_W     = 2;
  localparam int ANGLE_W    = 9;
  localparam int FACTOR_W   = 8;
  localparam int N_TERMS    = 2;
  localparam int N_LANES    = 2;
  localparam int LANE_X     = 0;
  localparam int LANE_Y     = 1;
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int QTR_LAST   = 90;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TRANSLATE = 2'd0,
    FUNC_ROTATE    = 2'd1,
    FUNC_SCALE     = 2'd2,
    FUNC_PASS      = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    REG_SHIFT_X = 3'd0,
    REG_SHIFT_Y = 3'd1,
    REG_ANGLE   = 3'd2,
    REG_FACTOR_X = 3'd3,
    REG_FACTOR_Y = 3'd4,
    REG_PIVOT_X = 3'd5,
    REG_PIVOT_Y = 3'd6
  } reg_idx_t;

  typedef struct packed {
    func_t                      func;
    logic signed [COORD_W-1:0]  point_x;
    logic signed [COORD_W-1:0]  point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  new_x;
    logic signed [COORD_W-1:0]  new_y;
    logic                       overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0]  shift_x;
    logic signed [COORD_W-1:0]  shift_y;
    logic [ANGLE_W-1:0]         angle_degrees;
    logic signed [FACTOR_W-1:0] factor_x;
    logic signed [FACTOR_W-1:0] factor_y;
    logic signed [COORD_W-1:0]  pivot_x;
    logic signed [COORD_W-1:0]  pivot_y;
  } cfg_regs_t;

  typedef struct packed {
    logic valid;
    logic rot;
  } ctl_t;

  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned HALF_TURN = 64'd180;
  localparam longint unsigned TAYLOR_DIV [1:11] =
    '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506};

  typedef logic [31:0] trig_tab_t [0:QTR_LAST];

  // Quarter-wave sine for 0 to 90 degrees with frac fraction bits. The
  // series runs in Q30 and is rounded half up at the end.
  function automatic trig_tab_t sin_table(input int frac);
    trig_tab_t       tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned one_q30;
    one_q30 = longint'(1) << 30;
    for (int d = 0; d <= QTR_LAST; d++) begin
      x    = (longint'(d) * PI_Q30) / HALF_TURN;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int n = 1; n < 12; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n];
        if ((n % 2) == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      if (sum > one_q30) begin
        sum = one_q30;
      end
      if (frac < 30) begin
        sum = (sum + (longint'(1) << (29 - frac))) >> (30 - frac);
      end
      tab[d] = sum[31:0];
    end
    return tab;
  endfunction

endpackage

// File: design/pt2d_front.sv
// ----------------------------------------------------------------------------
// pt2d_front
// Entry stage: forms the pivot offsets, looks up sine and cosine, and loads
// the base value and the product terms of each lane for the cell chain.
// ----------------------------------------------------------------------------
module pt2d_front #(
  parameter int TRIG_FRAC_BITS = 15,
  localparam int TRIG_W = TRIG_FRAC_BITS + 2,
  localparam int A_W    = pt2d_pkg::COORD_W + 1,
  localparam int B_W    = TRIG_W,
  localparam int ACC_W  = A_W + B_W
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  pt2d_pkg::in_item_t                     in_data,
  input  pt2d_pkg::cfg_regs_t                    cfg,
  output pt2d_pkg::ctl_t                         ctl_out,
  output logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0] acc_out,
  output logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][A_W-1:0] a_out,
  output logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][B_W-1:0] b_out
);

  localparam pt2d_pkg::trig_tab_t SIN_TAB = pt2d_pkg::sin_table(TRIG_FRAC_BITS);

  function automatic logic signed [TRIG_W-1:0] sin_deg(
    input logic [pt2d_pkg::ANGLE_W-1:0] a
  );
    logic [pt2d_pkg::ANGLE_W-1:0] idx;
    logic                         neg;
    logic signed [TRIG_W-1:0]     mag;
    if (a <= pt2d_pkg::DEG_90) begin
      idx = a;
      neg = 1'b0;
    end else if (a <= pt2d_pkg::DEG_180) begin
      idx = pt2d_pkg::DEG_180 - a;
      neg = 1'b0;
    end else if (a <= pt2d_pkg::DEG_270) begin
      idx = a - pt2d_pkg::DEG_180;
      neg = 1'b1;
    end else begin
      idx = pt2d_pkg::DEG_360 - a;
      neg = 1'b1;
    end
    mag = signed'({1'b0, SIN_TAB[idx[6:0]][TRIG_FRAC_BITS:0]});
    return neg ? -mag : mag;
  endfunction

  logic [pt2d_pkg::ANGLE_W-1:0] ang_w;
  logic [pt2d_pkg::ANGLE_W:0]   ang_c_ext;
  logic [pt2d_pkg::ANGLE_W-1:0] ang_c;
  logic signed [TRIG_W-1:0]     sin_v;
  logic signed [TRIG_W-1:0]     cos_v;
  logic signed [A_W-1:0]        dx;
  logic signed [A_W-1:0]        dy;

  pt2d_pkg::ctl_t                                       ctl_r, ctl_nxt;
  logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0]              acc_r, acc_nxt;
  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][A_W-1:0] a_r, a_nxt;
  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][B_W-1:0] b_r, b_nxt;

  always_comb begin
    ang_w = (cfg.angle_degrees >= pt2d_pkg::DEG_360) ?
            cfg.angle_degrees - pt2d_pkg::DEG_360 : cfg.angle_degrees;
    ang_c_ext = {1'b0, ang_w} + {1'b0, pt2d_pkg::DEG_90};
    ang_c = (ang_c_ext >= {1'b0, pt2d_pkg::DEG_360}) ?
            pt2d_pkg::ANGLE_W'(ang_c_ext - {1'b0, pt2d_pkg::DEG_360}) :
            ang_c_ext[pt2d_pkg::ANGLE_W-1:0];
    sin_v = sin_deg(ang_w);
    cos_v = sin_deg(ang_c);
    dx = A_W'(in_data.point_x) - A_W'(cfg.pivot_x);
    dy = A_W'(in_data.point_y) - A_W'(cfg.pivot_y);
  end

  always_comb begin
    ctl_nxt.valid = in_valid;
    ctl_nxt.rot   = 1'b0;
    acc_nxt[pt2d_pkg::LANE_X] = ACC_W'(in_data.point_x);
    acc_nxt[pt2d_pkg::LANE_Y] = ACC_W'(in_data.point_y);
    a_nxt = '0;
    b_nxt = '0;
    case (in_data.func)
      pt2d_pkg::FUNC_TRANSLATE: begin
        acc_nxt[pt2d_pkg::LANE_X] = ACC_W'(in_data.point_x) + ACC_W'(cfg.shift_x);
        acc_nxt[pt2d_pkg::LANE_Y] = ACC_W'(in_data.point_y) + ACC_W'(cfg.shift_y);
      end
      pt2d_pkg::FUNC_ROTATE: begin
        ctl_nxt.rot = 1'b1;
        acc_nxt[pt2d_pkg::LANE_X] = ACC_W'(cfg.pivot_x) <<< TRIG_FRAC_BITS;
        acc_nxt[pt2d_pkg::LANE_Y] = ACC_W'(cfg.pivot_y) <<< TRIG_FRAC_BITS;
        a_nxt[pt2d_pkg::LANE_X][0] = dx;
        b_nxt[pt2d_pkg::LANE_X][0] = cos_v;
        a_nxt[pt2d_pkg::LANE_X][1] = dy;
        b_nxt[pt2d_pkg::LANE_X][1] = -sin_v;
        a_nxt[pt2d_pkg::LANE_Y][0] = dx;
        b_nxt[pt2d_pkg::LANE_Y][0] = sin_v;
        a_nxt[pt2d_pkg::LANE_Y][1] = dy;
        b_nxt[pt2d_pkg::LANE_Y][1] = cos_v;
      end
      pt2d_pkg::FUNC_SCALE: begin
        acc_nxt[pt2d_pkg::LANE_X] = ACC_W'(cfg.pivot_x);
        acc_nxt[pt2d_pkg::LANE_Y] = ACC_W'(cfg.pivot_y);
        a_nxt[pt2d_pkg::LANE_X][0] = dx;
        b_nxt[pt2d_pkg::LANE_X][0] = B_W'(cfg.factor_x);
        a_nxt[pt2d_pkg::LANE_Y][0] = dy;
        b_nxt[pt2d_pkg::LANE_Y][0] = B_W'(cfg.factor_y);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign acc_out = acc_r;
  assign a_out   = a_r;
  assign b_out   = b_r;

endmodule

// File: design/pt2d_mac_cell.sv
// ----------------------------------------------------------------------------
// pt2d_mac_cell
// One multiply-accumulate cell of the chain. Each lane adds the product of
// its first pending term to the running sum and hands the remaining terms on.
// ----------------------------------------------------------------------------
module pt2d_mac_cell #(
  parameter int A_W = 17,
  parameter int B_W = 17,
  localparam int ACC_W = A_W + B_W
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  pt2d_pkg::ctl_t                         ctl_in,
  input  logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0] acc_in,
  input  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][A_W-1:0] a_in,
  input  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][B_W-1:0] b_in,
  output pt2d_pkg::ctl_t                         ctl_out,
  output logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0] acc_out,
  output logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][A_W-1:0] a_out,
  output logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][B_W-1:0] b_out
);

  logic signed [ACC_W-1:0] prod [pt2d_pkg::N_LANES];

  pt2d_pkg::ctl_t                                       ctl_r;
  logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0]              acc_r, acc_nxt;
  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][A_W-1:0] a_r, a_nxt;
  logic [pt2d_pkg::N_LANES-1:0][pt2d_pkg::N_TERMS-1:0][B_W-1:0] b_r, b_nxt;

  always_comb begin
    for (int l = 0; l < pt2d_pkg::N_LANES; l++) begin
      prod[l] = $signed(a_in[l][0]) * $signed(b_in[l][0]);
      acc_nxt[l] = acc_in[l] + prod[l];
      for (int k = 0; k < pt2d_pkg::N_TERMS - 1; k++) begin
        a_nxt[l][k] = a_in[l][k+1];
        b_nxt[l][k] = b_in[l][k+1];
      end
      a_nxt[l][pt2d_pkg::N_TERMS-1] = '0;
      b_nxt[l][pt2d_pkg::N_TERMS-1] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_nxt;
      a_r   <= a_nxt;
      b_r   <= b_nxt;
    end
  end

  assign ctl_out = ctl_r;
  assign acc_out = acc_r;
  assign a_out   = a_r;
  assign b_out   = b_r;

endmodule

// File: design/pt2d_sat.sv
// ----------------------------------------------------------------------------
// pt2d_sat
// Output stage: drops the trig fraction of a rotation toward zero, saturates
// both coordinates to the output range and holds the finished item.
// ----------------------------------------------------------------------------
module pt2d_sat #(
  parameter int TRIG_FRAC_BITS = 15,
  localparam int ACC_W = pt2d_pkg::COORD_W + TRIG_FRAC_BITS + 3
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  pt2d_pkg::ctl_t                         ctl_in,
  input  logic [pt2d_pkg::N_LANES-1:0][ACC_W-1:0] acc_in,
  output logic                                   out_valid,
  output pt2d_pkg::out_item_t                    out_data
);

  localparam logic signed [ACC_W-1:0] RND =
    ACC_W'((longint'(1) <<< TRIG_FRAC_BITS) - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    ACC_W'((longint'(1) <<< (pt2d_pkg::COORD_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  logic signed [ACC_W-1:0]             q [pt2d_pkg::N_LANES];
  logic signed [pt2d_pkg::COORD_W-1:0] coord [pt2d_pkg::N_LANES];
  logic                                ovf;

  logic                out_valid_r;
  pt2d_pkg::out_item_t out_data_r, out_data_nxt;

  always_comb begin
    ovf = 1'b0;
    for (int l = 0; l < pt2d_pkg::N_LANES; l++) begin
      q[l] = $signed(acc_in[l]);
      if (ctl_in.rot) begin
        if (q[l] < 0) begin
          q[l] = q[l] + RND;
        end
        q[l] = q[l] >>> TRIG_FRAC_BITS;
      end
      if (q[l] > SAT_HI) begin
        coord[l] = SAT_HI[pt2d_pkg::COORD_W-1:0];
        ovf = 1'b1;
      end else if (q[l] < SAT_LO) begin
        coord[l] = SAT_LO[pt2d_pkg::COORD_W-1:0];
        ovf = 1'b1;
      end else begin
        coord[l] = q[l][pt2d_pkg::COORD_W-1:0];
      end
    end
    out_data_nxt.new_x    = coord[pt2d_pkg::LANE_X];
    out_data_nxt.new_y    = coord[pt2d_pkg::LANE_Y];
    out_data_nxt.overflow = ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: design/point_transform_2d.sv
// ----------------------------------------------------------------------------
// point_transform_2d
// Translates, rotates about a pivot, scales about a pivot or passes through one 2-D point.
// ----------------------------------------------------------------------------
// The block takes one item per clock while in_stall is low and returns each
// result through an entry stage that forms the offsets and looks up sine
// and cosine, a chain of two multiply-accumulate cells (one product term
// each, both axes side by side), and a saturating output register.
// Every stage moves on its own as soon as the stage after it has room, so
// a stalled result does not stop new items until the chain is full. The
// user must write configuration registers over the APB port only while no
// item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module point_transform_2d #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pt2d_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pt2d_pkg::out_item_t                 out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pt2d_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [pt2d_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [pt2d_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int A_W   = pt2d_pkg::COORD_W + 1;
  localparam int B_W   = TRIG_FRAC_BITS + 2;
  localparam int ACC_W = A_W + B_W;
  localparam int NT    = pt2d_pkg::N_TERMS;
  localparam int NL    = pt2d_pkg::N_LANES;

  localparam pt2d_pkg::cfg_regs_t CFG_RESET = '{
    shift_x:       '0,
    shift_y:       '0,
    angle_degrees: '0,
    factor_x:      pt2d_pkg::FACTOR_W'(1),
    factor_y:      pt2d_pkg::FACTOR_W'(1),
    pivot_x:       '0,
    pivot_y:       '0
  };

  pt2d_pkg::cfg_regs_t cfg_r, cfg_nxt;
  pt2d_pkg::reg_idx_t  reg_idx;
  logic                cfg_wr;

  pt2d_pkg::ctl_t                          ctl_s [NT+1];
  logic [NL-1:0][ACC_W-1:0]                acc_s [NT+1];
  logic [NL-1:0][NT-1:0][A_W-1:0]          a_s   [NT+1];
  logic [NL-1:0][NT-1:0][B_W-1:0]          b_s   [NT+1];
  logic [NT:0]                             take;
  logic                                    out_take;

  assign reg_idx = pt2d_pkg::reg_idx_t'(paddr[pt2d_pkg::CFG_ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      case (reg_idx)
        pt2d_pkg::REG_SHIFT_X:  cfg_nxt.shift_x = pwdata[pt2d_pkg::COORD_W-1:0];
        pt2d_pkg::REG_SHIFT_Y:  cfg_nxt.shift_y = pwdata[pt2d_pkg::COORD_W-1:0];
        pt2d_pkg::REG_ANGLE:    cfg_nxt.angle_degrees = pwdata[pt2d_pkg::ANGLE_W-1:0];
        pt2d_pkg::REG_FACTOR_X: cfg_nxt.factor_x = pwdata[pt2d_pkg::FACTOR_W-1:0];
        pt2d_pkg::REG_FACTOR_Y: cfg_nxt.factor_y = pwdata[pt2d_pkg::FACTOR_W-1:0];
        pt2d_pkg::REG_PIVOT_X:  cfg_nxt.pivot_x = pwdata[pt2d_pkg::COORD_W-1:0];
        pt2d_pkg::REG_PIVOT_Y:  cfg_nxt.pivot_y = pwdata[pt2d_pkg::COORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      pt2d_pkg::REG_SHIFT_X:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.shift_x));
      pt2d_pkg::REG_SHIFT_Y:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.shift_y));
      pt2d_pkg::REG_ANGLE:
        prdata = pt2d_pkg::CFG_DATA_W'(cfg_r.angle_degrees);
      pt2d_pkg::REG_FACTOR_X:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.factor_x));
      pt2d_pkg::REG_FACTOR_Y:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.factor_y));
      pt2d_pkg::REG_PIVOT_X:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.pivot_x));
      pt2d_pkg::REG_PIVOT_Y:
        prdata = pt2d_pkg::CFG_DATA_W'($unsigned(cfg_r.pivot_y));
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_take = !out_valid || !out_stall;

  for (genvar k = 0; k <= NT; k++) begin : g_take
    if (k == NT) begin : g_last
      assign take[k] = !ctl_s[k].valid || out_take;
    end else begin : g_mid
      assign take[k] = !ctl_s[k].valid || take[k+1];
    end
  end

  assign in_stall = !take[0];

  pt2d_front #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (take[0]),
    .in_valid (in_valid),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .ctl_out  (ctl_s[0]),
    .acc_out  (acc_s[0]),
    .a_out    (a_s[0]),
    .b_out    (b_s[0])
  );

  for (genvar k = 0; k < NT; k++) begin : g_cell
    pt2d_mac_cell #(
      .A_W (A_W),
      .B_W (B_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (take[k+1]),
      .ctl_in  (ctl_s[k]),
      .acc_in  (acc_s[k]),
      .a_in    (a_s[k]),
      .b_in    (b_s[k]),
      .ctl_out (ctl_s[k+1]),
      .acc_out (acc_s[k+1]),
      .a_out   (a_s[k+1]),
      .b_out   (b_s[k+1])
    );
  end

  pt2d_sat #(
    .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (out_take),
    .ctl_in    (ctl_s[NT]),
    .acc_in    (acc_s[NT]),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: tb/tb_point_transform_2d.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_point_transform_2d
// Self-checking bench for the 2-D point transform.
// ----------------------------------------------------------------------------
// A short directed run covers the coordinate extremes, every operation, the
// pass-through operation code, angle wrap past a full turn and a write to an
// unused register. Then several register settings each carry 175 random
// items, sent in bursts against a receiver that stalls at random and
// now and then holds off long enough to back the pipeline up. Every result
// is compared field by field with an independent predictor.
// ----------------------------------------------------------------------------
module tb_point_transform_2d;

  localparam int TRIG_FRAC = 15;
  localparam longint TRIG_ONE = longint'(1) << TRIG_FRAC;
  localparam longint unsigned RAD_PI_Q30 = 64'd3373259426;
  localparam int REG_UNUSED = 7;
  localparam int LATENCY = 4;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int LIMIT_NS = 4_000_000;
  localparam int LONG_HOLD_SPAN = 15;

  class point_ledger;
    pt2d_pkg::cfg_regs_t regs;
    longint quarter_sine [0:90];
    pt2d_pkg::out_item_t expected_points [$];
    int mismatches;

    function new();
      longint unsigned rad, rad_sq, term, acc;
      regs = '0;
      regs.factor_x = 8'sd1;
      regs.factor_y = 8'sd1;
      mismatches = 0;
      for (int d = 0; d <= 90; d++) begin
        rad = (longint'(d) * RAD_PI_Q30) / 64'd180;
        rad_sq = (rad * rad) >> 30;
        term = rad;
        acc = rad;
        for (int n = 1; n < 12; n++) begin
          term = ((term * rad_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
          if ((n % 2) == 1) begin
            acc = (acc >= term) ? acc - term : 64'd0;
          end else begin
            acc = acc + term;
          end
        end
        if (acc > (64'd1 << 30)) begin
          acc = 64'd1 << 30;
        end
        quarter_sine[d] = longint'((acc + (64'd1 << (29 - TRIG_FRAC))) >> (30 - TRIG_FRAC));
      end
    endfunction

    function void apply_write(int idx, int value);
      case (idx)
        pt2d_pkg::REG_SHIFT_X:  regs.shift_x = value[15:0];
        pt2d_pkg::REG_SHIFT_Y:  regs.shift_y = value[15:0];
        pt2d_pkg::REG_ANGLE:    regs.angle_degrees = value[8:0];
        pt2d_pkg::REG_FACTOR_X: regs.factor_x = value[7:0];
        pt2d_pkg::REG_FACTOR_Y: regs.factor_y = value[7:0];
        pt2d_pkg::REG_PIVOT_X:  regs.pivot_x = value[15:0];
        pt2d_pkg::REG_PIVOT_Y:  regs.pivot_y = value[15:0];
        default: ;
      endcase
    endfunction

    function longint sine_deg(int a);
      if (a <= 90) return quarter_sine[a];
      if (a <= 180) return quarter_sine[180 - a];
      if (a <= 270) return -quarter_sine[a - 180];
      return -quarter_sine[360 - a];
    endfunction

    function longint shift_down(longint v);
      if (v < 0) return -((-v) >>> TRIG_FRAC);
      return v >>> TRIG_FRAC;
    endfunction

    function logic signed [15:0] clamp_coord(longint v, inout bit ov);
      if (v > 32767) begin
        ov = 1'b1;
        return 16'sh7fff;
      end
      if (v < -32768) begin
        ov = 1'b1;
        return 16'sh8000;
      end
      return v[15:0];
    endfunction

    function pt2d_pkg::out_item_t predict_point(pt2d_pkg::in_item_t it);
      longint x, y, px, py, nx, ny, dx, dy, s, c;
      int a, ac;
      bit ov;
      pt2d_pkg::out_item_t r;
      x = longint'($signed(it.point_x));
      y = longint'($signed(it.point_y));
      px = longint'($signed(regs.pivot_x));
      py = longint'($signed(regs.pivot_y));
      nx = x;
      ny = y;
      ov = 1'b0;
      case (it.func)
        pt2d_pkg::FUNC_TRANSLATE: begin
          nx = x + longint'($signed(regs.shift_x));
          ny = y + longint'($signed(regs.shift_y));
        end
        pt2d_pkg::FUNC_ROTATE: begin
          a = int'(regs.angle_degrees);
          if (a >= 360) a = a - 360;
          ac = a + 90;
          if (ac >= 360) ac = ac - 360;
          s = sine_deg(a);
          c = sine_deg(ac);
          dx = x - px;
          dy = y - py;
          nx = shift_down(px * TRIG_ONE + dx * c - dy * s);
          ny = shift_down(py * TRIG_ONE + dx * s + dy * c);
        end
        pt2d_pkg::FUNC_SCALE: begin
          nx = px + longint'($signed(regs.factor_x)) * (x - px);
          ny = py + longint'($signed(regs.factor_y)) * (y - py);
        end
        pt2d_pkg::FUNC_PASS: ;
        default: ;
      endcase
      r.new_x = clamp_coord(nx, ov);
      r.new_y = clamp_coord(ny, ov);
      r.overflow = ov;
      return r;
    endfunction

    function void note_input(pt2d_pkg::in_item_t it);
      expected_points.push_back(predict_point(it));
    endfunction

    function int pending();
      return expected_points.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(pt2d_pkg::out_item_t got);
      pt2d_pkg::out_item_t want;
      if (expected_points.size() == 0) begin
        report($sformatf("result x=%0d y=%0d ov=%0b with nothing expected",
                         got.new_x, got.new_y, got.overflow));
        return;
      end
      want = expected_points.pop_front();
      if (got.new_x !== want.new_x)
        report($sformatf("new_x got %0d want %0d", got.new_x, want.new_x));
      if (got.new_y !== want.new_y)
        report($sformatf("new_y got %0d want %0d", got.new_y, want.new_y));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow got %0b want %0b", got.overflow, want.overflow));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pt2d_pkg::in_item_t in_data;
  logic out_valid;
  logic out_stall;
  pt2d_pkg::out_item_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [pt2d_pkg::CFG_ADDR_W-1:0] paddr;
  logic [pt2d_pkg::CFG_DATA_W-1:0] pwdata;
  logic [pt2d_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  point_ledger board = new();

  point_transform_2d #(.TRIG_FRAC_BITS(TRIG_FRAC)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_point_transform_2d: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // Receiver: free-running stretches, random stalls, and occasional long holds.
  initial begin
    int span, mode, spans;
    out_stall = 1'b0;
    spans = 0;
    forever begin
      mode = (spans == LONG_HOLD_SPAN) ? 9 : $urandom_range(0, 9);
      spans++;
      span = (mode == 9) ? $urandom_range(40, 100) : $urandom_range(5, 60);
      repeat (span) begin
        @(negedge clk);
        if (mode == 9) begin
          out_stall <= 1'b1;
        end else if (mode >= 4) begin
          out_stall <= ($urandom_range(0, 2) == 0);
        end else begin
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic send_item(pt2d_pkg::in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_input(it);
    @(negedge clk);
  endtask

  task automatic send_pt(pt2d_pkg::func_t f, int x, int y);
    pt2d_pkg::in_item_t it;
    it.func = f;
    it.point_x = 16'(x);
    it.point_y = 16'(y);
    send_item(it);
  endtask

  task automatic idle_sender(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
  endtask

  task automatic write_reg(int idx, int value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pt2d_pkg::CFG_ADDR_W'(idx * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    board.apply_write(idx, value);
    @(negedge clk);
  endtask

  task automatic release_bus();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] extreme_coord();
    case ($urandom_range(0, 3))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'shffff;
    endcase
  endfunction

  function automatic int pick_coord();
    if ($urandom_range(0, 3) == 0) return int'(extreme_coord());
    return int'($signed(16'($urandom)));
  endfunction

  function automatic int pick_factor();
    case ($urandom_range(0, 7))
      0: return -128;
      1: return 127;
      2: return int'($signed(8'($urandom)));
      default: return int'($urandom_range(0, 8)) - 4;
    endcase
  endfunction

  function automatic int pick_angle();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 3))
          0: return 0;
          1: return 359;
          2: return 360;
          default: return 511;
        endcase
      end
      1: return $urandom_range(360, 511);
      default: return $urandom_range(0, 359);
    endcase
  endfunction

  function automatic pt2d_pkg::in_item_t random_point();
    pt2d_pkg::in_item_t it;
    int off_x, off_y;
    if ($urandom_range(0, 7) == 0) begin
      it.func = pt2d_pkg::FUNC_PASS;
    end else begin
      it.func = pt2d_pkg::func_t'($urandom_range(0, 2));
    end
    off_x = int'($urandom_range(0, 1024)) - 512;
    off_y = int'($urandom_range(0, 1024)) - 512;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        it.point_x = 16'($urandom);
        it.point_y = 16'($urandom);
      end
      4, 5, 6: begin
        it.point_x = board.regs.pivot_x + 16'(off_x);
        it.point_y = board.regs.pivot_y + 16'(off_y);
      end
      7: begin
        it.point_x = extreme_coord();
        it.point_y = extreme_coord();
      end
      default: begin
        it.point_x = 16'(off_x / 5);
        it.point_y = 16'(off_y / 5);
      end
    endcase
    return it;
  endfunction

  task automatic run_bursts(int count);
    int burst, gap;
    while (count > 0) begin
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && count > 0; i++) begin
        send_item(random_point());
        count--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) idle_sender(gap);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pt(pt2d_pkg::FUNC_TRANSLATE, 32767, -32768);
    send_pt(pt2d_pkg::FUNC_ROTATE, 123, -456);
    send_pt(pt2d_pkg::FUNC_SCALE, -32768, 32767);
    send_pt(pt2d_pkg::FUNC_PASS, -1, 0);
    drain_results();

    write_reg(pt2d_pkg::REG_SHIFT_X, 32767);
    write_reg(pt2d_pkg::REG_SHIFT_Y, -32768);
    write_reg(pt2d_pkg::REG_ANGLE, 90);
    write_reg(pt2d_pkg::REG_FACTOR_X, -128);
    write_reg(pt2d_pkg::REG_FACTOR_Y, 127);
    write_reg(pt2d_pkg::REG_PIVOT_X, -32768);
    write_reg(pt2d_pkg::REG_PIVOT_Y, 32767);
    release_bus();
    send_pt(pt2d_pkg::FUNC_TRANSLATE, 32767, -32768);
    send_pt(pt2d_pkg::FUNC_TRANSLATE, -32768, 32767);
    send_pt(pt2d_pkg::FUNC_TRANSLATE, 0, 0);
    send_pt(pt2d_pkg::FUNC_ROTATE, 0, 0);
    send_pt(pt2d_pkg::FUNC_ROTATE, 32767, -32768);
    send_pt(pt2d_pkg::FUNC_ROTATE, -32768, 32767);
    send_pt(pt2d_pkg::FUNC_SCALE, -32767, 32766);
    send_pt(pt2d_pkg::FUNC_SCALE, 32767, -32768);
    send_pt(pt2d_pkg::FUNC_PASS, 32767, -32768);
    drain_results();

    write_reg(pt2d_pkg::REG_ANGLE, 511);
    write_reg(pt2d_pkg::REG_PIVOT_X, 0);
    write_reg(pt2d_pkg::REG_PIVOT_Y, 0);
    write_reg(pt2d_pkg::REG_FACTOR_X, 0);
    write_reg(pt2d_pkg::REG_FACTOR_Y, -1);
    release_bus();
    send_pt(pt2d_pkg::FUNC_ROTATE, 1000, -2000);
    send_pt(pt2d_pkg::FUNC_ROTATE, -32768, -32768);
    send_pt(pt2d_pkg::FUNC_SCALE, -32768, -32768);
    drain_results();

    // A write past the last register must leave every setting alone.
    write_reg(pt2d_pkg::REG_ANGLE, 360);
    write_reg(REG_UNUSED, 32'h0000_1234);
    release_bus();
    send_pt(pt2d_pkg::FUNC_ROTATE, -32768, 32767);
    send_pt(pt2d_pkg::FUNC_ROTATE, 12345, -54);
    drain_results();

    write_reg(pt2d_pkg::REG_ANGLE, 180);
    release_bus();
    send_pt(pt2d_pkg::FUNC_ROTATE, -32768, -32768);
    drain_results();
    write_reg(pt2d_pkg::REG_ANGLE, 270);
    release_bus();
    send_pt(pt2d_pkg::FUNC_ROTATE, 1, 2);
    drain_results();
    write_reg(pt2d_pkg::REG_ANGLE, 359);
    release_bus();
    send_pt(pt2d_pkg::FUNC_ROTATE, 30000, 30000);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      write_reg(pt2d_pkg::REG_SHIFT_X, pick_coord());
      write_reg(pt2d_pkg::REG_SHIFT_Y, pick_coord());
      write_reg(pt2d_pkg::REG_ANGLE, pick_angle());
      write_reg(pt2d_pkg::REG_FACTOR_X, pick_factor());
      write_reg(pt2d_pkg::REG_FACTOR_Y, pick_factor());
      write_reg(pt2d_pkg::REG_PIVOT_X, pick_coord());
      write_reg(pt2d_pkg::REG_PIVOT_Y, pick_coord());
      release_bus();
      run_bursts(ITEMS_PER_PHASE);
      drain_results();
    end

    repeat (2 * LATENCY) @(negedge clk);
    if (board.mismatches == 0) begin
      $display("tb_point_transform_2d: done, clean");
    end else begin
      $display("tb_point_transform_2d: done, errors");
    end
    $finish;
  end

endmodule
